// ----- hw/rtl/subarray_target_sum_counter_unit_assert.svh -----
// Assertion macros for the subarray target-sum counter.
// Both expect i_clk and i_rst_n in scope.
`ifndef SUBARRAY_TARGET_SUM_COUNTER_UNIT_ASSERT_SVH
`define SUBARRAY_TARGET_SUM_COUNTER_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define STSC_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication out of reset.
`define STSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/stsc_pkg.sv -----
package stsc_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int VAL_W        = 16;
    localparam int TGT_W        = 32;
    localparam int SUM_W        = 33;
    localparam int CNT_W        = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_PUSH,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_state           state;
        logic [OCC_W-1:0] occ;
        logic             sum_zero;
    } t_status;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- hw/rtl/stsc_if.sv -----
interface stsc_in_if;
    logic                           valid;
    logic                           ready;
    logic [stsc_pkg::VAL_W-1:0]     element_value;
    logic                           is_last;

    modport source(output valid, output element_value, output is_last, input ready);
    modport sink(input valid, input element_value, input is_last, output ready);
endinterface

interface stsc_out_if;
    logic                           valid;
    logic                           ready;
    logic [stsc_pkg::CNT_W-1:0]     match_total;
    logic                           window_overflow;

    modport source(output valid, output match_total, output window_overflow, input ready);
    modport sink(input valid, input match_total, input window_overflow, output ready);
endinterface

// ----- hw/rtl/stsc_in_queue.sv -----
module stsc_in_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stsc_in_if.sink        i_in,
    output logic           o_valid,
    output stsc_pkg::t_item o_item,
    input  logic           i_ready
);
    import stsc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push, pop;

    assign i_in.ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_item     = r_mem[r_rp];

    assign push = i_in.valid && i_in.ready;
    assign pop  = o_valid && i_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{value: i_in.element_value, last: i_in.is_last};
        end
    end

endmodule

// ----- hw/rtl/stsc_window_engine.sv -----
module stsc_window_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  stsc_pkg::t_item             i_q_item,
    output logic                        o_q_ready,
    input  logic [stsc_pkg::TGT_W-1:0]  i_target,
    stsc_out_if.source                  o_out,
    output stsc_pkg::t_status           o_status
);
    import stsc_pkg::*;

    logic [VAL_W-1:0] r_store [WINDOW_DEPTH];

    t_state           r_state, n_state;
    logic [VAL_W-1:0] r_val;
    logic             r_last;
    logic [PTR_W-1:0] r_head, r_tail;
    logic [OCC_W-1:0] r_occ;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_total;
    logic             r_out_ovf;
    logic [VAL_W-1:0] r_rd_data;
    logic             r_fwd;
    logic [VAL_W-1:0] r_fwd_data;

    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [VAL_W-1:0] pop_data;
    logic [PTR_W-1:0] head_inc;
    logic [SUM_W-1:0] tgt;
    logic [SUM_W-1:0] push_sum, pop_sum;
    logic [OCC_W-1:0] pop_occ;
    logic             full;
    logic             prune_push, prune_pop;
    logic             out_free;
    logic             done_go;
    logic [CNT_W-1:0] cnt_next;

    // datapath
    always_comb begin
        pop_data   = r_fwd ? r_fwd_data : r_rd_data;
        head_inc   = ptr_adv(r_head);
        tgt        = SUM_W'(i_target);
        push_sum   = r_sum + SUM_W'(r_val);
        pop_sum    = r_sum - SUM_W'(pop_data);
        pop_occ    = r_occ - 1'b1;
        full       = (r_occ == OCC_W'(WINDOW_DEPTH));
        prune_push = (push_sum > tgt);
        prune_pop  = (pop_sum > tgt) && (pop_occ != '0);
        out_free   = !r_out_valid || o_out.ready;
        done_go    = !r_last || out_free;
        cnt_next   = ((r_sum == tgt) && (r_cnt != CNT_MAX)) ? r_cnt + 1'b1 : r_cnt;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = full ? S_EVICT : S_PUSH;
                end
            end
            S_EVICT: n_state = S_PUSH;
            S_PUSH:  n_state = prune_push ? S_POP : S_DONE;
            S_POP:   n_state = prune_pop ? S_POP : S_DONE;
            S_DONE: begin
                if (done_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_ready = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = r_head;
        case (r_state)
            S_IDLE:  o_q_ready = 1'b1;
            S_EVICT: rd_addr   = r_head;
            S_PUSH:  wr_en     = 1'b1;
            // prefetch the next oldest entry while this one is subtracted
            S_POP:   rd_addr   = head_inc;
            S_DONE:  rd_addr   = r_head;
            default: rd_addr   = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_tail] <= r_val;
        end
        r_rd_data  <= r_store[rd_addr];
        r_fwd_data <= r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_state <= n_state;
            // write and read of the same entry in one cycle: take the new data
            r_fwd   <= wr_en && (rd_addr == r_tail);
            if (r_state == S_DONE && r_last && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_EVICT: begin
                    r_sum  <= pop_sum;
                    r_head <= head_inc;
                    r_occ  <= pop_occ;
                    r_ovf  <= 1'b1;
                end
                S_PUSH: begin
                    r_sum  <= push_sum;
                    r_tail <= ptr_adv(r_tail);
                    r_occ  <= r_occ + 1'b1;
                end
                S_POP: begin
                    r_sum  <= pop_sum;
                    r_head <= head_inc;
                    r_occ  <= pop_occ;
                end
                S_DONE: begin
                    if (done_go) begin
                        if (r_last) begin
                            r_head <= '0;
                            r_tail <= '0;
                            r_occ  <= '0;
                            r_sum  <= '0;
                            r_cnt  <= '0;
                            r_ovf  <= 1'b0;
                        end else begin
                            r_cnt  <= cnt_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_val  <= i_q_item.value;
            r_last <= i_q_item.last;
        end
        if (r_state == S_DONE && r_last && out_free) begin
            r_out_total <= cnt_next;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.match_total     = r_out_total;
    assign o_out.window_overflow = r_out_ovf;

    assign o_status = '{state: r_state, occ: r_occ, sum_zero: (r_sum == '0)};

endmodule

// ----- hw/rtl/subarray_target_sum_counter_unit.sv -----
// Each element passes the engine states IDLE, EVICT (only when the window store is full),
// PUSH, one POP per element popped from the window, and DONE, holding a last element
// until o_out is free. A new element is taken only in IDLE; pops are limited by the one
// read port of the window store (one pop per cycle), each popped at most once.
// Reset (i_rst_n low, synchronous) sets the target to 1, empties the window and clears
// the count and overflow flag; the window store contents are not cleared.
`include "subarray_target_sum_counter_unit_assert.svh"

module subarray_target_sum_counter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stsc_pkg::TGT_W-1:0] i_cfg_data,
    stsc_in_if.sink                    i_in,
    stsc_out_if.source                 o_out
);
    import stsc_pkg::*;

    logic [TGT_W-1:0] r_target;
    logic             q_valid;
    t_item            q_item;
    logic             q_ready;
    t_status          w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    stsc_in_queue u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    stsc_window_engine u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_ready (q_ready),
        .i_target  (r_target),
        .o_out     (o_out),
        .o_status  (w_status)
    );

    `STSC_ASSERT_HOLD(a_occ_bound, w_status.occ <= OCC_W'(WINDOW_DEPTH), "window occupancy above depth")
    `STSC_ASSERT_IMPLY(a_empty_sum, w_status.occ == '0, w_status.sum_zero, "empty window with nonzero sum")
    `STSC_ASSERT_IMPLY(a_out_from_done, o_out.valid && !$past(o_out.valid), $past(w_status.state == S_DONE), "result raised outside done step")

endmodule
